### src/att_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_pkg: shared types and constants of the acknowledgement tracking table
// Field widths, operation and status codes, and the item that moves
// along the row of table cells.
// ----------------------------------------------------------------------------
package att_pkg;

	localparam int MSG_W         = 16;
	localparam int PID_W         = 22;
	localparam int KEY_W         = MSG_W + 2 * PID_W;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int DEFAULT_DEPTH = 16;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_EXISTS = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

	// One request travelling down the row of cells, with the flags that
	// the cells it has passed have collected so far.
	typedef struct packed {
		logic             vld;
		logic             claim;  // write pass: first free cell takes the key
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic             found;  // some cell held the full key
		logic             free;   // some cell was free
		logic             qhit;   // some used cell matched message and receiver
		logic             done;   // the write pass has placed the key
	} pkt_t;

	function automatic logic [KEY_W-1:0] pack_key(
		input logic [MSG_W-1:0] msg,
		input logic [PID_W-1:0] rcv,
		input logic [PID_W-1:0] snd
	);
		return {msg, rcv, snd};
	endfunction

endpackage
`default_nettype wire

### src/att_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_if: request and response channels of the acknowledgement table
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface att_req_if;
	logic                        valid;
	logic                        ready;
	logic [att_pkg::OP_W-1:0]    opcode;
	logic [att_pkg::MSG_W-1:0]   msg_id;
	logic [att_pkg::PID_W-1:0]   receiver_id;
	logic [att_pkg::PID_W-1:0]   sender_id;

	modport source(output valid, opcode, msg_id, receiver_id, sender_id, input ready);
	modport sink(input valid, opcode, msg_id, receiver_id, sender_id, output ready);
endinterface

interface att_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [att_pkg::STATUS_W-1:0] status;

	modport source(output valid, status, input ready);
	modport sink(input valid, status, output ready);
endinterface
`default_nettype wire

### src/ack_tracking_table.sv
`default_nettype none
// A delete, exists or query item makes one search pass down the row before
// its response is loaded; an insert that stores its key makes a second,
// write pass first. The table takes one item at a time: the next item is
// taken only after the response is loaded into the output register, and the
// response is loaded only when that register is empty or being emptied.
// Reset clears every slot.
// ----------------------------------------------------------------------------
// ack_tracking_table: content-searched table of acknowledgement keys
// A row of cells, each holding one key, searched by a request that walks
// the row one cell per cycle.
// ----------------------------------------------------------------------------
module ack_tracking_table #(
	parameter int TABLE_DEPTH = att_pkg::DEFAULT_DEPTH
) (
	input wire logic   clk,
	input wire logic   arst_n,
	att_req_if.sink    req,
	att_rsp_if.source  rsp
);

	// The controller is a small sequencer. Every item first makes a search
	// pass down the row. Each cell folds its compare results into the flags
	// of the passing item, and a delete clears the first matching slot on
	// the way. An insert whose key is absent and that saw a free slot makes a
	// second, write pass in which the first free cell takes the key.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_CLAIM,
		S_REPLY
	} state_t;

	state_t                         state_q;
	att_pkg::pkt_t                  inj_q;
	att_pkg::pkt_t                  inj_d;
	logic [att_pkg::OP_W-1:0]       op_q;
	logic [att_pkg::KEY_W-1:0]      key_q;
	logic [att_pkg::KEY_W-1:0]      req_key;
	logic                           start_claim;
	logic [att_pkg::STATUS_W-1:0]   st_q;
	logic                           rsp_vld_q;
	logic [att_pkg::STATUS_W-1:0]   rsp_status_q;

	att_pkg::pkt_t                  chain [TABLE_DEPTH+1];
	att_pkg::pkt_t                  exit_pkt;

	assign chain[0] = inj_q;
	assign exit_pkt = chain[TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		att_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.pkt_in  (chain[i]),
			.pkt_out (chain[i+1])
		);
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_vld_q;
	assign rsp.status = rsp_status_q;

	assign req_key = att_pkg::pack_key(req.msg_id, req.receiver_id, req.sender_id);

	// The search pass of an insert has come back with the key absent and a
	// free slot seen, so the key goes down the row once more to be stored.
	assign start_claim = (state_q == S_SEARCH) && exit_pkt.vld &&
		(op_q == att_pkg::OP_INSERT) && !exit_pkt.found && exit_pkt.free;

	// The injection register holds an item for exactly one cycle.
	always_comb begin
		inj_d     = inj_q;
		inj_d.vld = 1'b0;
		if (state_q == S_IDLE && req.valid) begin
			inj_d = '{vld: 1'b1, claim: 1'b0, op: req.opcode, key: req_key,
				found: 1'b0, free: 1'b0, qhit: 1'b0, done: 1'b0};
		end else if (start_claim) begin
			inj_d = '{vld: 1'b1, claim: 1'b1, op: op_q, key: key_q,
				found: 1'b0, free: 1'b0, qhit: 1'b0, done: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			inj_q        <= '0;
			op_q         <= att_pkg::OP_INSERT;
			key_q        <= '0;
			st_q         <= att_pkg::ST_DONE;
			rsp_vld_q    <= 1'b0;
			rsp_status_q <= att_pkg::ST_DONE;
		end else begin
			inj_q <= inj_d;
			// The output register is loaded when it is empty or being emptied.
			if (state_q == S_REPLY && (!rsp_vld_q || rsp.ready)) begin
				rsp_vld_q    <= 1'b1;
				rsp_status_q <= st_q;
			end else if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.opcode;
						key_q   <= req_key;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (exit_pkt.vld) begin
						unique case (op_q) inside
							att_pkg::OP_INSERT: begin
								if (exit_pkt.found) begin
									st_q    <= att_pkg::ST_ABSENT;
									state_q <= S_REPLY;
								end else if (!exit_pkt.free) begin
									st_q    <= att_pkg::ST_FULL;
									state_q <= S_REPLY;
								end else begin
									// Key is new and a slot is free: write pass.
									state_q <= S_CLAIM;
								end
							end
							att_pkg::OP_DELETE, att_pkg::OP_EXISTS: begin
								st_q    <= exit_pkt.found ? att_pkg::ST_DONE : att_pkg::ST_ABSENT;
								state_q <= S_REPLY;
							end
							att_pkg::OP_QUERY: begin
								st_q    <= exit_pkt.qhit ? att_pkg::ST_DONE : att_pkg::ST_ABSENT;
								state_q <= S_REPLY;
							end
							default: begin
								st_q    <= att_pkg::ST_ABSENT;
								state_q <= S_REPLY;
							end
						endcase
					end
				end
				S_CLAIM: begin
					if (exit_pkt.vld) begin
						st_q    <= att_pkg::ST_DONE;
						state_q <= S_REPLY;
					end
				end
				S_REPLY: begin
					// Wait until the output register is empty or being emptied.
					if (!rsp_vld_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### src/att_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_cell: one slot of the acknowledgement table
// Holds one key, compares it with the passing request and registers the
// request with updated flags, forwarding it to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module att_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire att_pkg::pkt_t pkt_in,
	output att_pkg::pkt_t      pkt_out
);

	logic [att_pkg::KEY_W-1:0] entry_q;
	att_pkg::pkt_t             pkt_q;
	att_pkg::pkt_t             pkt_d;
	logic                      hit;
	logic                      is_free;
	logic                      qhit;
	logic                      entry_set;
	logic                      entry_clr;

	assign hit     = (entry_q == pkt_in.key);
	assign is_free = (entry_q == '0);
	assign qhit    = !is_free && (entry_q[att_pkg::KEY_W-1:att_pkg::PID_W] ==
		pkt_in.key[att_pkg::KEY_W-1:att_pkg::PID_W]);

	always_comb begin
		pkt_d     = pkt_in;
		entry_set = 1'b0;
		entry_clr = 1'b0;
		if (pkt_in.vld) begin
			if (pkt_in.claim) begin
				if (is_free && !pkt_in.done) begin
					entry_set  = 1'b1;
					pkt_d.done = 1'b1;
				end
			end else begin
				pkt_d.found = pkt_in.found | hit;
				pkt_d.free  = pkt_in.free | is_free;
				pkt_d.qhit  = pkt_in.qhit | qhit;
				// Delete clears only the first slot that holds the key.
				if (pkt_in.op == att_pkg::OP_DELETE && hit && !pkt_in.found) begin
					entry_clr = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			pkt_q   <= '0;
		end else begin
			pkt_q <= pkt_d;
			if (entry_set) begin
				entry_q <= pkt_in.key;
			end else if (entry_clr) begin
				entry_q <= '0;
			end
		end
	end

	assign pkt_out = pkt_q;

endmodule
`default_nettype wire

### src/att_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_chk: port checks of the acknowledgement tracking table
// Watches the channels of the top level and flags illegal sequences.
// ----------------------------------------------------------------------------
module att_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_ready,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_ready,
	input wire logic [att_pkg::STATUS_W-1:0] rsp_status
);

	// A held response keeps its status until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("response dropped or changed while stalled");

	// Status stays within the defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= att_pkg::ST_FULL)
		else $error("response carries an unused status code");

	// The table works on one item at a time: it is busy after taking one.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready ##1 !req_ready)
		else $error("item taken while another is in the table");

	// A new response rises only out of a busy table, one whose ready was low.
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response without an item in the table");

endmodule

bind ack_tracking_table att_chk u_att_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status)
);
`default_nettype wire
